FILE: sv/assert_macros.svh
// Assertion macros shared by the frame ownership table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FOT_ASSERT(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

`define FOT_ASSERT_NEVER(label, clock, rstn, cond) \
	label: assert property (@(posedge clock) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");

`else

`define FOT_ASSERT(label, clock, rstn, prop)

`define FOT_ASSERT_NEVER(label, clock, rstn, cond)

`endif

`endif

FILE: sv/fot_pkg.sv
// Types and constants of the frame ownership table.
// No dependencies; imported by frame_ownership_table and tb_top.
`default_nettype none

package fot_pkg;

	localparam int NUM_FRAMES   = 128;
	localparam int PROC_ID_BITS = 8;
	localparam int PAGE_BITS    = 6;
	localparam int FRAME_BITS   = $clog2(NUM_FRAMES);
	localparam int COUNT_BITS   = $clog2(NUM_FRAMES + 1);

	localparam logic [1:0] REQ_FREE_CHECK = 2'd0;
	localparam logic [1:0] REQ_LOOKUP     = 2'd1;
	localparam logic [1:0] REQ_ALLOCATE   = 2'd2;
	localparam logic [1:0] REQ_RELEASE    = 2'd3;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [PROC_ID_BITS-1:0] proc_id;
		logic [PAGE_BITS-1:0]    page_no;
		logic [COUNT_BITS-1:0]   needed_frames;
	} fot_req_t;

	typedef struct packed {
		logic                  success;
		logic [FRAME_BITS-1:0] frame_index;
		logic [COUNT_BITS-1:0] free_count;
	} fot_rsp_t;

	typedef struct packed {
		logic [PROC_ID_BITS-1:0] proc_id;
		logic [PAGE_BITS-1:0]    page_no;
	} fot_owner_t;

endpackage

`default_nettype wire

FILE: sv/frame_ownership_table.sv
// Frame ownership table: 128 frames, one scan of the owner memory per lookup, allocate or release.
// Lookup, allocate and release read all 128 entries through the single read port of the
// owner memory in ST_SCAN, then pass ST_WAIT and ST_FINISH before the done strobe;
// a free check goes straight to ST_FINISH. A new item may start in the strobe cycle.
// Reset frees every frame and clears the free counter to the full count;
// the owner memory is not cleared. Results cannot be stalled.
`default_nettype none
`include "assert_macros.svh"

module frame_ownership_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire fot_pkg::fot_req_t req,
	output logic                   busy,
	output logic                   done,
	output fot_pkg::fot_rsp_t      result
);
	import fot_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(NUM_FRAMES - 1);
	localparam logic [COUNT_BITS-1:0] ALL_FREE   = COUNT_BITS'(NUM_FRAMES);

	logic [1:0]              state_q;
	fot_req_t                req_q;
	logic [FRAME_BITS-1:0]   scan_q;
	logic [FRAME_BITS-1:0]   idx_s1;
	logic                    vld_s1;
	fot_owner_t              rd_s1;
	fot_owner_t              owner_mem [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]   in_use_q;
	logic [COUNT_BITS-1:0]   free_q;
	logic                    hit_q;
	logic [FRAME_BITS-1:0]   hit_idx_q;
	logic                    done_q;
	fot_rsp_t                result_q;

	logic                    accept;
	logic                    cur_in_use;
	logic                    lookup_match;
	logic                    alloc_match;
	logic                    release_match;
	logic                    alloc_commit;

	assign accept        = start && !busy;
	assign cur_in_use    = in_use_q[idx_s1];
	assign lookup_match  = vld_s1 && (req_q.req_type == REQ_LOOKUP) && cur_in_use &&
		(rd_s1.proc_id == req_q.proc_id) && (rd_s1.page_no == req_q.page_no);
	assign alloc_match   = vld_s1 && (req_q.req_type == REQ_ALLOCATE) && !cur_in_use;
	assign release_match = vld_s1 && (req_q.req_type == REQ_RELEASE) && cur_in_use &&
		(rd_s1.proc_id == req_q.proc_id);
	assign alloc_commit  = (state_q == ST_FINISH) && (req_q.req_type == REQ_ALLOCATE) && hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (accept) begin
						if (req.req_type == REQ_FREE_CHECK) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST_FRAME) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_FINISH;
				ST_FINISH: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		idx_s1 <= scan_q;
		rd_s1  <= owner_mem[scan_q];
		if (alloc_commit) begin
			owner_mem[hit_idx_q] <= '{proc_id: req_q.proc_id, page_no: req_q.page_no};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
		end else if (accept) begin
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
		end else if (!hit_q && (lookup_match || alloc_match)) begin
			hit_q     <= 1'b1;
			hit_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			free_q   <= ALL_FREE;
		end else if (release_match) begin
			in_use_q[idx_s1] <= 1'b0;
			free_q           <= free_q + 1'b1;
		end else if (alloc_commit) begin
			in_use_q[hit_idx_q] <= 1'b1;
			free_q              <= free_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			case (req_q.req_type)
				REQ_FREE_CHECK: begin
					result_q.success     <= (free_q >= req_q.needed_frames);
					result_q.frame_index <= '0;
					result_q.free_count  <= free_q;
				end
				REQ_LOOKUP: begin
					result_q.success     <= hit_q;
					result_q.frame_index <= hit_idx_q;
					result_q.free_count  <= free_q;
				end
				REQ_ALLOCATE: begin
					result_q.success     <= hit_q;
					result_q.frame_index <= hit_idx_q;
					result_q.free_count  <= hit_q ? free_q - 1'b1 : free_q;
				end
				default: begin
					result_q.success     <= 1'b1;
					result_q.frame_index <= '0;
					result_q.free_count  <= free_q;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`FOT_ASSERT(a_done_after_finish, clk, arst_n, done |-> $past(state_q == ST_FINISH))
	`FOT_ASSERT(a_fail_index_zero, clk, arst_n, (done && !result.success) |-> (result.frame_index == '0))
	`FOT_ASSERT_NEVER(a_free_overflow, clk, arst_n, free_q > ALL_FREE)
	`FOT_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> busy)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for frame_ownership_table: free check, lookup, allocate, release.
// Holds its own model of the frame table and compares every strobed result with it.
// Depends on fot_pkg and the frame_ownership_table RTL.
`default_nettype none

module tb_top;
	import fot_pkg::*;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

	class ownership_checker_t;
		bit                    in_use [NUM_FRAMES];
		bit [PROC_ID_BITS-1:0] owner_pid [NUM_FRAMES];
		bit [PAGE_BITS-1:0]    owner_pg [NUM_FRAMES];
		fot_rsp_t              pending_rsp [$];
		int                    mismatches;
		int                    strays;

		function int free_frames();
			int n;
			n = 0;
			for (int i = 0; i < NUM_FRAMES; i++)
				if (!in_use[i])
					n++;
			return n;
		endfunction

		function fot_rsp_t predict_response(fot_req_t r);
			fot_rsp_t rsp;
			bit       found;
			rsp = '0;
			found = 1'b0;
			case (r.req_type)
				REQ_FREE_CHECK: begin
					rsp.success = (free_frames() >= int'(r.needed_frames));
				end
				REQ_LOOKUP: begin
					for (int i = 0; i < NUM_FRAMES; i++)
						if (!found && in_use[i] && owner_pid[i] == r.proc_id
								&& owner_pg[i] == r.page_no) begin
							found = 1'b1;
							rsp.success = 1'b1;
							rsp.frame_index = FRAME_BITS'(i);
						end
				end
				REQ_ALLOCATE: begin
					for (int i = 0; i < NUM_FRAMES; i++)
						if (!found && !in_use[i]) begin
							found = 1'b1;
							in_use[i] = 1'b1;
							owner_pid[i] = r.proc_id;
							owner_pg[i] = r.page_no;
							rsp.success = 1'b1;
							rsp.frame_index = FRAME_BITS'(i);
						end
				end
				default: begin
					for (int i = 0; i < NUM_FRAMES; i++)
						if (in_use[i] && owner_pid[i] == r.proc_id)
							in_use[i] = 1'b0;
					rsp.success = 1'b1;
				end
			endcase
			rsp.free_count = COUNT_BITS'(free_frames());
			return rsp;
		endfunction

		function void note_request(fot_req_t r);
			pending_rsp.push_back(predict_response(r));
		endfunction

		function void check_response(fot_rsp_t got);
			fot_rsp_t want;
			if (pending_rsp.size() == 0) begin
				strays++;
				if (mismatches + strays <= 10)
					$display("unexpected result: success=%0d frame=%0d free=%0d",
						got.success, got.frame_index, got.free_count);
				return;
			end
			want = pending_rsp.pop_front();
			if (got.success !== want.success || got.frame_index !== want.frame_index
					|| got.free_count !== want.free_count) begin
				mismatches++;
				if (mismatches + strays <= 10)
					$display("mismatch: exp ok/frame/free %0d/%0d/%0d got %0d/%0d/%0d",
						want.success, want.frame_index, want.free_count,
						got.success, got.frame_index, got.free_count);
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     start;
	fot_req_t req;
	logic     busy;
	logic     done;
	fot_rsp_t result;

	ownership_checker_t sb = new();
	int                 items_sent;
	int                 burst_left;
	bit                 quiet;

	frame_ownership_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(req);
			if (done)
				sb.check_response(result);
		end
	end

	function automatic fot_req_t make_req(logic [1:0] kind, int pid, int pg, int need);
		fot_req_t r;
		r.req_type = kind;
		r.proc_id = PROC_ID_BITS'(pid);
		r.page_no = PAGE_BITS'(pg);
		r.needed_frames = COUNT_BITS'(need);
		return r;
	endfunction

	function automatic fot_req_t rand_request(traffic_mode_t mode, int pool[6]);
		int       w;
		int       f;
		logic [1:0] kind;
		fot_req_t r;
		w = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:  kind = (w < 70) ? REQ_ALLOCATE : (w < 85) ? REQ_LOOKUP :
				(w < 95) ? REQ_FREE_CHECK : REQ_RELEASE;
			MODE_DRAIN: kind = (w < 50) ? REQ_RELEASE : (w < 70) ? REQ_LOOKUP :
				(w < 85) ? REQ_FREE_CHECK : REQ_ALLOCATE;
			default:    kind = (w < 25) ? REQ_ALLOCATE : (w < 50) ? REQ_LOOKUP :
				(w < 75) ? REQ_FREE_CHECK : REQ_RELEASE;
		endcase
		r = make_req(kind, ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)] :
			$urandom_range(0, 255), $urandom_range(0, 63), 0);
		if (kind == REQ_LOOKUP && $urandom_range(0, 9) < 6) begin
			f = $urandom_range(0, NUM_FRAMES - 1);
			if (sb.in_use[f]) begin
				r.proc_id = sb.owner_pid[f];
				r.page_no = sb.owner_pg[f];
			end
		end
		w = $urandom_range(0, 9);
		if (w < 7) begin
			r.needed_frames = COUNT_BITS'($urandom_range(0, NUM_FRAMES));
		end else if (w < 8) begin
			f = sb.free_frames() + int'($urandom_range(0, 2)) - 1;
			if (f < 0)
				f = 0;
			r.needed_frames = COUNT_BITS'(f);
		end else begin
			r.needed_frames = COUNT_BITS'($urandom_range(0, 255));
		end
		return r;
	endfunction

	task automatic send_item(fot_req_t r);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic hold_off(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 20);
			hold_off(quiet ? 0 : $urandom_range(0, 12));
		end
	endtask

	initial begin
		int            pool [6];
		int            epoch_len;
		int            epoch;
		traffic_mode_t mode;
		fot_req_t      directed [$];

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		items_sent = 0;
		burst_left = 0;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		directed.push_back(make_req(REQ_FREE_CHECK, 0, 0, 0));
		directed.push_back(make_req(REQ_FREE_CHECK, 0, 0, 128));
		directed.push_back(make_req(REQ_FREE_CHECK, 255, 63, 129));
		directed.push_back(make_req(REQ_FREE_CHECK, 0, 0, 255));
		directed.push_back(make_req(REQ_LOOKUP, 0, 0, 0));
		directed.push_back(make_req(REQ_ALLOCATE, 0, 0, 0));
		directed.push_back(make_req(REQ_ALLOCATE, 255, 63, 0));
		directed.push_back(make_req(REQ_ALLOCATE, 255, 63, 0));
		directed.push_back(make_req(REQ_LOOKUP, 255, 63, 0));
		directed.push_back(make_req(REQ_LOOKUP, 0, 0, 0));
		directed.push_back(make_req(REQ_LOOKUP, 255, 62, 0));
		directed.push_back(make_req(REQ_LOOKUP, 254, 63, 0));
		directed.push_back(make_req(REQ_FREE_CHECK, 0, 0, 125));
		directed.push_back(make_req(REQ_FREE_CHECK, 0, 0, 126));
		directed.push_back(make_req(REQ_RELEASE, 7, 0, 0));
		directed.push_back(make_req(REQ_RELEASE, 255, 0, 0));
		directed.push_back(make_req(REQ_LOOKUP, 255, 63, 0));
		directed.push_back(make_req(REQ_ALLOCATE, 170, 42, 0));
		directed.push_back(make_req(REQ_ALLOCATE, 85, 21, 0));
		directed.push_back(make_req(REQ_LOOKUP, 85, 21, 0));
		directed.push_back(make_req(REQ_RELEASE, 0, 0, 0));
		directed.push_back(make_req(REQ_FREE_CHECK, 0, 0, 127));
		foreach (directed[i])
			send_item(directed[i]);
		wait_drained();

		epoch = 0;
		while (items_sent < 950) begin
			pool[0] = 0;
			pool[1] = 255;
			for (int i = 2; i < 6; i++)
				pool[i] = $urandom_range(0, 255);
			case ($urandom_range(0, 2))
				0: mode = MODE_FILL;
				1: mode = MODE_DRAIN;
				default: mode = MODE_MIXED;
			endcase
			if (epoch == 0)
				mode = MODE_FILL;
			quiet = ($urandom_range(0, 3) == 0);
			epoch_len = (mode == MODE_FILL) ? $urandom_range(150, 220) :
				$urandom_range(40, 150);
			repeat (epoch_len) begin
				if (items_sent >= 950)
					break;
				pace();
				send_item(rand_request(mode, pool));
			end
			if (epoch == 0 || $urandom_range(0, 1) == 1)
				wait_drained();
			epoch++;
		end

		wait_drained();
		repeat (140) @(posedge clk);
		if (sb.mismatches == 0 && sb.strays == 0 && sb.pending_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/fot_pkg.sv
sv/frame_ownership_table.sv
tb/tb_top.sv
